// ----- sv/b64se_pkg.sv -----
// Shared types, constants and character functions for the Base64 stream encoder.
package b64se_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [6:0] PAD_CHAR   = 7'h3D;
  localparam logic [6:0] PLUS_CHAR  = 7'h2B;
  localparam logic [6:0] SLASH_CHAR = 7'h2F;
  localparam logic [6:0] UPPER_BASE = 7'h41;
  localparam logic [6:0] LOWER_BASE = 7'h61;
  localparam logic [6:0] DIGIT_BASE = 7'h30;

  localparam logic [1:0] CHAR_THIRD = 2'd2;
  localparam logic [1:0] CHAR_LAST  = 2'd3;

  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  n;
    logic        mark;
  } grp_t;

  typedef struct packed {
    logic valid;
    grp_t grp;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } out_char_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] v7;
    logic [6:0] r;
    v7 = {1'b0, v};
    if (v < 6'd26) begin
      r = UPPER_BASE + v7;
    end else if (v < 6'd52) begin
      r = LOWER_BASE + v7 - 7'd26;
    end else if (v < 6'd62) begin
      r = DIGIT_BASE + v7 - 7'd52;
    end else if (v == 6'd62) begin
      r = PLUS_CHAR;
    end else begin
      r = SLASH_CHAR;
    end
    return r;
  endfunction

  function automatic out_char_t group_char(input grp_t g, input logic [1:0] k);
    out_char_t  r;
    logic [5:0] s;
    unique case (k)
      2'd0: s = g.word[23:18];
      2'd1: s = g.word[17:12];
      2'd2: s = g.word[11:6];
      default: s = g.word[5:0];
    endcase
    r.code = sextet_char(s);
    r.last = 1'b0;
    if (k == CHAR_THIRD && g.n < 2'd2) begin
      r.code = PAD_CHAR;
    end
    if (k == CHAR_LAST) begin
      if (g.n < 2'd3) begin
        r.code = PAD_CHAR;
      end
      r.last = g.mark;
    end
    return r;
  endfunction

endpackage

// ----- sv/base64_stream_encoder.sv -----
// Top level of the Base64 stream encoder with '=' padding.
// A finished group is queued; its first character is then registered in the output register.
// Throughput: one item per cycle while the group queue has room; characters leave one per cycle
// while out_stall is low, four characters per group.
// Reset (synchronous, active low) clears the pending byte count, the queue and the serializer.
module base64_stream_encoder import b64se_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char_code,
  output logic       out_last_char
);

  push_t   push;
  q_stat_t q_stat;
  grp_t    head;
  logic    pop;

  b64se_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .q_stat            (q_stat),
    .push              (push)
  );

  b64se_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  b64se_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.valid && q_stat.full))
    else $error("group written into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("group taken from an empty queue");

  a_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code >= PLUS_CHAR))
    else $error("output character outside the Base64 set");

endmodule

// ----- sv/b64se_front.sv -----
// Input side: collects bytes into three-byte groups and queues finished groups.
module b64se_front import b64se_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_end_of_message,
  input  q_stat_t    q_stat,
  output push_t      push
);

  logic [15:0] pend_bytes_r, pend_bytes_nxt;
  logic [1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [1:0]  cnt;
  logic        accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    cnt            = (pend_cnt_r == 2'd3) ? 2'd0 : pend_cnt_r;
    pend_bytes_nxt = pend_bytes_r;
    pend_cnt_nxt   = cnt;
    push           = '0;
    if (in_byte_present && cnt == 2'd2) begin
      push.valid    = accept;
      push.grp.word = {pend_bytes_r, in_data_byte};
      push.grp.n    = 2'd3;
      push.grp.mark = in_end_of_message;
      pend_cnt_nxt  = 2'd0;
    end else begin
      if (in_byte_present) begin
        if (cnt == 2'd0) begin
          pend_bytes_nxt = {in_data_byte, 8'h00};
        end else begin
          pend_bytes_nxt = {pend_bytes_r[15:8], in_data_byte};
        end
        pend_cnt_nxt = cnt + 2'd1;
      end
      if (in_end_of_message && pend_cnt_nxt != 2'd0) begin
        push.valid    = accept;
        push.grp.word = {pend_bytes_nxt, 8'h00};
        push.grp.n    = pend_cnt_nxt;
        push.grp.mark = 1'b1;
        pend_cnt_nxt  = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= 2'd0;
    end else if (accept) begin
      pend_cnt_r <= pend_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_bytes_r <= pend_bytes_nxt;
    end
  end

endmodule

// ----- sv/b64se_queue.sv -----
// Short group queue between the input side and the character serializer.
module b64se_queue import b64se_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  logic    pop,
  output grp_t    head,
  output q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grp_t          entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push.valid) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries_r[wr_ptr_r] <= push.grp;
    end
  end

endmodule

// ----- sv/b64se_back.sv -----
// Output side: turns each queued group into four characters, one per cycle while out_stall is low.
module b64se_back import b64se_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  grp_t       head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char_code,
  output logic       out_last_char
);

  grp_t       grp_r, grp_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_char_t  out_r, out_nxt;
  logic       adv;

  assign adv           = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_char_code = out_r.code;
  assign out_last_char = out_r.last;

  always_comb begin
    grp_nxt       = grp_r;
    idx_nxt       = idx_r;
    busy_nxt      = busy_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    pop           = 1'b0;
    if (adv) begin
      out_valid_nxt = 1'b0;
      if (busy_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = group_char(grp_r, idx_r);
        idx_nxt       = idx_r + 2'd1;
        if (idx_r == CHAR_LAST) begin
          busy_nxt = 1'b0;
        end
      end else if (!q_stat.empty) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        out_nxt       = group_char(head, 2'd0);
        grp_nxt       = head;
        idx_nxt       = 2'd1;
        busy_nxt      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    out_r <= out_nxt;
  end

endmodule
